FILE: sv/clj_pkg.sv
package clj_pkg;

  // Width of the squared distance once it has passed the cutoff check
  localparam int unsigned R2_W = 48;
  // Width of a quotient or numerator in the divide chain (cap is 2^62)
  localparam int unsigned QW = 63;
  // Quotient bits produced after the range check
  localparam int unsigned QBITS = 62;
  localparam logic [QW-1:0] QUOT_CAP = {1'b1, 62'd0};

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_REPULSIVE  = 3'd0,
    REG_ATTRACTIVE = 3'd1,
    REG_CUTOFF     = 3'd2,
    REG_LIM_BETWEEN = 3'd3,
    REG_LIM_WITHIN = 3'd4,
    REG_TIME_STEP  = 3'd5
  } reg_idx_t;

  // Side data that travels with each pair through the divide chain
  typedef struct packed {
    logic signed [32:0] d_x;
    logic signed [32:0] d_y;
    logic signed [32:0] d_z;
    logic [R2_W-1:0]    r2;
    logic               skip;
    logic               same;
    logic               dneg;
  } carry_t;

endpackage

FILE: sv/clj_div.sv
// Pipelined divide: q = min(floor(x * 2^32 / r2), 2^62), one quotient bit per stage
module clj_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      ce,
  input  logic                      in_valid,
  input  logic [clj_pkg::QW-1:0]    in_x,
  input  clj_pkg::carry_t           in_c,
  output logic                      out_valid,
  output logic [clj_pkg::QW-1:0]    out_q,
  output clj_pkg::carry_t           out_c
);
  import clj_pkg::*;

  logic              v_r   [0:QBITS];
  logic              cap_r [0:QBITS];
  logic [R2_W-1:0]   rem_r [0:QBITS];
  logic [QBITS-1:0]  n_r   [0:QBITS];
  logic [QBITS-1:0]  q_r   [0:QBITS];
  carry_t            c_r   [0:QBITS];

  logic [R2_W:0]     t_c   [0:QBITS-1];
  logic              ge_c  [0:QBITS-1];
  logic [R2_W-1:0]   rem_nxt [0:QBITS-1];
  logic              cap_c;

  // Range check: the quotient reaches the cap when x >= r2 * 2^30
  assign cap_c = {15'd0, in_x} >= {in_c.r2, 30'd0};

  // One restoring step per stage
  always_comb begin
    for (int i = 0; i < QBITS; i++) begin
      t_c[i]     = {rem_r[i], n_r[i][QBITS-1]};
      ge_c[i]    = t_c[i] >= {1'b0, c_r[i].r2};
      rem_nxt[i] = ge_c[i] ? R2_W'(t_c[i] - {1'b0, c_r[i].r2}) : t_c[i][R2_W-1:0];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= QBITS; i++) v_r[i] <= 1'b0;
    end else if (ce) begin
      v_r[0] <= in_valid;
      for (int i = 0; i < QBITS; i++) v_r[i+1] <= v_r[i];
    end
  end

  // Data path
  always_ff @(posedge clk) begin
    if (ce) begin
      cap_r[0] <= cap_c;
      rem_r[0] <= R2_W'(in_x[QW-1:30]);
      n_r[0]   <= {in_x[29:0], 32'd0};
      q_r[0]   <= '0;
      c_r[0]   <= in_c;
      for (int i = 0; i < QBITS; i++) begin
        cap_r[i+1] <= cap_r[i];
        rem_r[i+1] <= rem_nxt[i];
        n_r[i+1]   <= {n_r[i][QBITS-2:0], 1'b0};
        q_r[i+1]   <= {q_r[i][QBITS-2:0], ge_c[i]};
        c_r[i+1]   <= c_r[i];
      end
    end
  end

  assign out_valid = v_r[QBITS];
  assign out_q     = cap_r[QBITS] ? QUOT_CAP : {1'b0, q_r[QBITS]};
  assign out_c     = c_r[QBITS];

endmodule

FILE: sv/clamped_lennard_jones_pair.sv
// Clamped Lennard-Jones pair displacement.
// Input stream (in_*): one word per particle pair, two Q8.24 positions in
// in_tdata and the same-complex flag in in_tuser. Output stream (out_*): one
// word per pair, three Q8.24 displacements in out_tdata, skipped flag in
// out_tuser. Configuration (cfg_*): index and 32-bit data, always ready;
// write only while no pair is in flight.
// From input to out_tvalid a pair passes through seven divides by the
// squared distance at 63 register stages each (a range check plus one
// quotient bit per stage), plus three offset, square and sum stages, one
// difference stage, three clamp and scale stages and the output register.
// Throughput is one pair per cycle while the skid register is empty.
// Reset clears the configuration registers and all valid bits, which
// empties the pipeline.
// When the receiver stalls, one finished word waits in the output register
// and one more in a skid register; the pipeline and in_tready freeze as soon
// as the skid register fills and resume the cycle after it empties.
module clamped_lennard_jones_pair (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z
  input  logic [191:0] in_tdata,
  // same_complex
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // move_x, move_y, move_z
  output logic [95:0]  out_tdata,
  // skipped
  output logic [0:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import clj_pkg::*;

  logic [31:0] rep_r, att_r, cut_r, limb_r, limw_r, ts_r;
  logic        ce;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_r <= '0; att_r <= '0; cut_r <= '0;
      limb_r <= '0; limw_r <= '0; ts_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_REPULSIVE:   rep_r  <= cfg_data;
        REG_ATTRACTIVE:  att_r  <= cfg_data;
        REG_CUTOFF:      cut_r  <= cfg_data;
        REG_LIM_BETWEEN: limb_r <= cfg_data;
        REG_LIM_WITHIN:  limw_r <= cfg_data;
        REG_TIME_STEP:   ts_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: offsets
  logic               v1_r;
  logic signed [32:0] dx1_r, dy1_r, dz1_r;
  logic               same1_r;

  function automatic logic signed [32:0] sub33(input logic [31:0] a, input logic [31:0] b);
    sub33 = $signed({a[31], a}) - $signed({b[31], b});
  endfunction

  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    abs33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  // ---------------- stage 2: squares
  logic               v2_r;
  logic signed [32:0] dx2_r, dy2_r, dz2_r;
  logic [49:0]        sx2_r, sy2_r, sz2_r;
  logic               same2_r;
  logic [65:0]        sqx_c, sqy_c, sqz_c;

  // ---------------- stage 3: r2, skip
  logic               v3_r;
  carry_t             c3_r;
  logic [51:0]        r2sum_c;
  logic               skip_c;

  assign sqx_c   = abs33(dx1_r) * abs33(dx1_r);
  assign sqy_c   = abs33(dy1_r) * abs33(dy1_r);
  assign sqz_c   = abs33(dz1_r) * abs33(dz1_r);
  assign r2sum_c = 52'(sx2_r) + 52'(sy2_r) + 52'(sz2_r);
  assign skip_c  = (dx2_r == '0 && dy2_r == '0 && dz2_r == '0) ||
                   (r2sum_c > {4'd0, cut_r, 16'd0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dx1_r   <= sub33(in_tdata[31:0],   in_tdata[127:96]);
      dy1_r   <= sub33(in_tdata[63:32],  in_tdata[159:128]);
      dz1_r   <= sub33(in_tdata[95:64],  in_tdata[191:160]);
      same1_r <= in_tuser[0];
      dx2_r   <= dx1_r; dy2_r <= dy1_r; dz2_r <= dz1_r;
      sx2_r   <= sqx_c[65:16];
      sy2_r   <= sqy_c[65:16];
      sz2_r   <= sqz_c[65:16];
      same2_r <= same1_r;
      c3_r.d_x  <= dx2_r;
      c3_r.d_y  <= dy2_r;
      c3_r.d_z  <= dz2_r;
      c3_r.r2   <= (r2sum_c == '0) ? R2_W'(1) : r2sum_c[R2_W-1:0];
      c3_r.skip <= skip_c;
      c3_r.same <= same2_r;
      c3_r.dneg <= 1'b0;
    end
  end

  // ---------------- T = A / r2^3
  logic          av [0:3];
  logic [QW-1:0] aq [0:3];
  carry_t        ac [0:3];

  assign av[0] = v3_r;
  assign aq[0] = QW'(rep_r);
  assign ac[0] = c3_r;

  for (genvar k = 0; k < 3; k++) begin : g_div_a
    clj_div u_div (
      .clk(clk), .rst_n(rst_n), .ce(ce),
      .in_valid(av[k]), .in_x(aq[k]), .in_c(ac[k]),
      .out_valid(av[k+1]), .out_q(aq[k+1]), .out_c(ac[k+1])
    );
  end

  // ---------------- D = T - B, magnitude and sign
  logic          vd_r;
  logic [QW-1:0] magd_r;
  carry_t        cd_r;
  carry_t        cd_c;
  logic [63:0]   diff_c;

  assign diff_c = {1'b0, aq[3]} - {32'd0, att_r};

  // side data with the sign of D
  always_comb begin
    cd_c      = ac[3];
    cd_c.dneg = diff_c[63];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vd_r <= 1'b0;
    else if (ce) vd_r <= av[3];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      magd_r <= diff_c[63] ? QW'(-diff_c) : diff_c[QW-1:0];
      cd_r   <= cd_c;
    end
  end

  // ---------------- |f| = |D| / r2^4
  logic          bv [0:4];
  logic [QW-1:0] bq [0:4];
  carry_t        bc [0:4];

  assign bv[0] = vd_r;
  assign bq[0] = magd_r;
  assign bc[0] = cd_r;

  for (genvar k = 0; k < 4; k++) begin : g_div_b
    clj_div u_div (
      .clk(clk), .rst_n(rst_n), .ce(ce),
      .in_valid(bv[k]), .in_x(bq[k]), .in_c(bc[k]),
      .out_valid(bv[k+1]), .out_q(bq[k+1]), .out_c(bc[k+1])
    );
  end

  // ---------------- clamp
  logic               vf_r, fneg_r, skipf_r;
  logic [32:0]        fm_r;
  logic signed [32:0] dxf_r, dyf_r, dzf_r;
  logic [31:0]        lim_c;
  logic [32:0]        fm_c;
  logic               fneg_c;

  assign lim_c = bc[4].same ? limw_r : limb_r;

  always_comb begin
    if (!bc[4].dneg) begin
      fm_c   = (bq[4] > QW'(lim_c)) ? {1'b0, lim_c} : bq[4][32:0];
      fneg_c = 1'b0;
    end else begin
      fm_c   = (bq[4] > {30'd0, 33'h1_0000_0000}) ? 33'h1_0000_0000 : bq[4][32:0];
      fneg_c = bq[4] != '0;
    end
  end

  // ---------------- g = time_step * |f|
  logic               vg_r, fneg_g_r, skip_g_r;
  logic [31:0]        g_r;
  logic signed [32:0] dxg_r, dyg_r, dzg_r;
  logic [64:0]        gprod_c;

  assign gprod_c = ts_r * fm_r;

  // ---------------- per-axis products
  logic               vm_r, skip_m_r;
  logic [48:0]        mx_r, my_r, mz_r;
  logic               nx_r, ny_r, nz_r;
  logic [64:0]        px_c, py_c, pz_c;

  assign px_c = g_r * abs33(dxg_r);
  assign py_c = g_r * abs33(dyg_r);
  assign pz_c = g_r * abs33(dzg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0; vg_r <= 1'b0; vm_r <= 1'b0;
    end else if (ce) begin
      vf_r <= bv[4];
      vg_r <= vf_r;
      vm_r <= vg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      fm_r     <= fm_c;
      fneg_r   <= fneg_c;
      skipf_r  <= bc[4].skip;
      dxf_r    <= bc[4].d_x; dyf_r <= bc[4].d_y; dzf_r <= bc[4].d_z;
      g_r      <= gprod_c[63:32];
      fneg_g_r <= fneg_r;
      skip_g_r <= skipf_r;
      dxg_r    <= dxf_r; dyg_r <= dyf_r; dzg_r <= dzf_r;
      mx_r     <= px_c[64:16];
      my_r     <= py_c[64:16];
      mz_r     <= pz_c[64:16];
      nx_r     <= fneg_g_r != dxg_r[32];
      ny_r     <= fneg_g_r != dyg_r[32];
      nz_r     <= fneg_g_r != dzg_r[32];
      skip_m_r <= skip_g_r;
    end
  end

  // Signed saturation of one displacement
  function automatic logic [31:0] sat32(input logic [48:0] m, input logic neg,
                                        input logic skip);
    if (skip || m == '0)             sat32 = '0;
    else if (neg && m > 49'h0_8000_0000)  sat32 = 32'h8000_0000;
    else if (neg)                    sat32 = 32'(-m);
    else if (m > 49'h0_7FFF_FFFF)    sat32 = 32'h7FFF_FFFF;
    else                             sat32 = m[31:0];
  endfunction

  logic [95:0] res_c;
  assign res_c = {sat32(mz_r, nz_r, skip_m_r), sat32(my_r, ny_r, skip_m_r),
                  sat32(mx_r, nx_r, skip_m_r)};

  // ---------------- output register and skid
  logic        out_valid_r, skid_valid_r;
  logic [95:0] out_data_r, skid_data_r;
  logic        out_skip_r, skid_skip_r;
  logic        emerge;

  assign ce        = !skid_valid_r;
  assign in_tready = ce;
  assign emerge    = ce && vm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= emerge;
      end
    end else if (emerge) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
        out_skip_r <= skid_skip_r;
      end else begin
        out_data_r <= res_c;
        out_skip_r <= skip_m_r;
      end
    end else if (emerge) begin
      skid_data_r <= res_c;
      skid_skip_r <= skip_m_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_skip_r;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r) else $error("skid word without output word");
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid filled while output free");
  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("skipped pair with nonzero move");
`endif

endmodule
